// ===== hw/rtl/utcp_pkg.sv =====
// shared types, constants and helpers for the utc timestamp parser
`timescale 1ns / 1ps
`default_nettype none

package utcp_pkg;

    localparam int FRACTION_DIGITS = 6;

    localparam int CHAR_W   = 8;
    localparam int POS_W    = 5;
    localparam int YEAR_W   = 14;
    localparam int FIELD_W  = 7;
    localparam int NS_W     = 30;
    localparam int DIGIT_W  = 4;

    localparam int IN_TDATA_W     = 8;
    localparam int RESULT_W       = 2 + YEAR_W + 5 * FIELD_W + NS_W;
    localparam int OUT_TDATA_W    = ((RESULT_W + 7) / 8) * 8;

    // character positions inside the fixed part
    localparam logic [POS_W-1:0] POS_YEAR_END   = 5'd3;
    localparam logic [POS_W-1:0] POS_MONTH_END  = 5'd6;
    localparam logic [POS_W-1:0] POS_DAY_END    = 5'd9;
    localparam logic [POS_W-1:0] POS_T          = 5'd10;
    localparam logic [POS_W-1:0] POS_HOUR_END   = 5'd12;
    localparam logic [POS_W-1:0] POS_MINUTE_END = 5'd15;
    localparam logic [POS_W-1:0] POS_SECOND_END = 5'd18;
    localparam logic [POS_W-1:0] POS_FIXED_LEN  = 5'd19;
    localparam logic [POS_W-1:0] POS_DASH_1     = 5'd4;
    localparam logic [POS_W-1:0] POS_DASH_2     = 5'd7;
    localparam logic [POS_W-1:0] POS_COLON_1    = 5'd13;
    localparam logic [POS_W-1:0] POS_COLON_2    = 5'd16;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_T     = 8'h54;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DATE_ERR = 2'd1,
        ST_TIME_ERR = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        PH_FIXED,
        PH_FRAC,
        PH_DONE,
        PH_ERROR
    } t_phase;

    // status in the lowest bits, nanoseconds in the highest
    typedef struct packed {
        logic [NS_W-1:0]    nanoseconds;
        logic [FIELD_W-1:0] second;
        logic [FIELD_W-1:0] minute;
        logic [FIELD_W-1:0] hour;
        logic [FIELD_W-1:0] day;
        logic [FIELD_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        t_status            status;
    } t_result;

    // nanosecond weight of a fraction digit, index is 8 minus digits already taken
    function automatic logic [NS_W-1:0] ns_weight(input logic [DIGIT_W-1:0] idx);
        logic [NS_W-1:0] w;
        unique case (idx)
            4'd0:    w = 30'd1;
            4'd1:    w = 30'd10;
            4'd2:    w = 30'd100;
            4'd3:    w = 30'd1000;
            4'd4:    w = 30'd10000;
            4'd5:    w = 30'd100000;
            4'd6:    w = 30'd1000000;
            4'd7:    w = 30'd10000000;
            4'd8:    w = 30'd100000000;
            default: w = 30'd0;
        endcase
        return w;
    endfunction

    function automatic t_status part_error(input logic [POS_W-1:0] pos);
        return (pos <= POS_T) ? ST_DATE_ERR : ST_TIME_ERR;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/utcp_core.sv =====
// parser state, field accumulators and per-character next-state logic
`timescale 1ns / 1ps
`default_nettype none

module utcp_core #(
    parameter int FRACTION_DIGITS = utcp_pkg::FRACTION_DIGITS
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_take,
    input  wire  [utcp_pkg::CHAR_W-1:0]     i_char,
    input  wire                             i_last,
    output logic                            o_done,
    output utcp_pkg::t_result               o_result
);

    localparam int CNT_W = $clog2(FRACTION_DIGITS + 1);

    logic [utcp_pkg::POS_W-1:0]    r_pos,    n_pos;
    utcp_pkg::t_phase              r_phase,  n_phase;
    logic                          r_halted, n_halted;
    utcp_pkg::t_status             r_err,    n_err;
    logic [utcp_pkg::YEAR_W-1:0]   r_year,   n_year;
    logic [utcp_pkg::FIELD_W-1:0]  r_month,  n_month;
    logic [utcp_pkg::FIELD_W-1:0]  r_day,    n_day;
    logic [utcp_pkg::FIELD_W-1:0]  r_hour,   n_hour;
    logic [utcp_pkg::FIELD_W-1:0]  r_minute, n_minute;
    logic [utcp_pkg::FIELD_W-1:0]  r_second, n_second;
    logic [utcp_pkg::NS_W-1:0]     r_ns,     n_ns;
    logic [CNT_W-1:0]              r_fcnt,   n_fcnt;

    logic                          is_digit;
    logic [utcp_pkg::DIGIT_W-1:0]  digit;
    logic                          is_sep;
    logic [utcp_pkg::CHAR_W-1:0]   sep_char;
    logic [utcp_pkg::POS_W-1:0]    pos_inc;
    logic [utcp_pkg::DIGIT_W-1:0]  w_idx;

    assign is_digit = (i_char >= utcp_pkg::CH_ZERO) && (i_char <= utcp_pkg::CH_NINE);
    assign digit    = utcp_pkg::DIGIT_W'(i_char - utcp_pkg::CH_ZERO);
    assign pos_inc  = r_pos + 5'd1;
    assign w_idx    = 4'd8 - utcp_pkg::DIGIT_W'(r_fcnt);

    always_comb begin
        is_sep   = 1'b1;
        sep_char = utcp_pkg::CH_DASH;
        unique case (r_pos)
            utcp_pkg::POS_DASH_1, utcp_pkg::POS_DASH_2: sep_char = utcp_pkg::CH_DASH;
            utcp_pkg::POS_T: sep_char = utcp_pkg::CH_T;
            utcp_pkg::POS_COLON_1, utcp_pkg::POS_COLON_2: sep_char = utcp_pkg::CH_COLON;
            default: is_sep = 1'b0;
        endcase
    end

    always_comb begin
        n_pos    = r_pos;
        n_phase  = r_phase;
        n_halted = r_halted;
        n_err    = r_err;
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        n_ns     = r_ns;
        n_fcnt   = r_fcnt;

        if (r_phase == utcp_pkg::PH_FIXED) begin
            if (is_sep) begin
                if (i_char != sep_char) begin
                    n_err   = utcp_pkg::part_error(r_pos);
                    n_phase = utcp_pkg::PH_ERROR;
                end
                n_halted = 1'b0;
            end else if (r_pos <= utcp_pkg::POS_SECOND_END) begin
                if (i_char == utcp_pkg::CH_NUL) begin
                    n_err   = utcp_pkg::part_error(r_pos);
                    n_phase = utcp_pkg::PH_ERROR;
                end else if (!r_halted && is_digit) begin
                    priority if (r_pos <= utcp_pkg::POS_YEAR_END) begin
                        n_year = 14'(r_year * 14'd10) + 14'(digit);
                    end else if (r_pos <= utcp_pkg::POS_MONTH_END) begin
                        n_month = 7'(r_month * 7'd10) + 7'(digit);
                    end else if (r_pos <= utcp_pkg::POS_DAY_END) begin
                        n_day = 7'(r_day * 7'd10) + 7'(digit);
                    end else if (r_pos <= utcp_pkg::POS_HOUR_END) begin
                        n_hour = 7'(r_hour * 7'd10) + 7'(digit);
                    end else if (r_pos <= utcp_pkg::POS_MINUTE_END) begin
                        n_minute = 7'(r_minute * 7'd10) + 7'(digit);
                    end else begin
                        n_second = 7'(r_second * 7'd10) + 7'(digit);
                    end
                end else begin
                    n_halted = 1'b1;
                end
            end else begin
                n_phase = (i_char == utcp_pkg::CH_DOT) ? utcp_pkg::PH_FRAC
                                                       : utcp_pkg::PH_DONE;
            end
            if (n_phase != utcp_pkg::PH_ERROR) begin
                n_pos = pos_inc;
                if (i_last && pos_inc < utcp_pkg::POS_FIXED_LEN) begin
                    n_err   = utcp_pkg::part_error(pos_inc);
                    n_phase = utcp_pkg::PH_ERROR;
                end
            end
        end else if (r_phase == utcp_pkg::PH_FRAC) begin
            if (is_digit) begin
                if (r_fcnt < CNT_W'(FRACTION_DIGITS)) begin
                    n_ns   = r_ns + utcp_pkg::NS_W'(digit * utcp_pkg::ns_weight(w_idx));
                    n_fcnt = r_fcnt + CNT_W'(1);
                end
            end else begin
                n_phase = utcp_pkg::PH_DONE;
            end
        end
    end

    always_comb begin
        o_done   = i_take && i_last;
        o_result = '0;
        o_result.status = n_err;
        if (n_err == utcp_pkg::ST_OK) begin
            o_result.year        = n_year;
            o_result.month       = n_month;
            o_result.day         = n_day;
            o_result.hour        = n_hour;
            o_result.minute      = n_minute;
            o_result.second      = n_second;
            o_result.nanoseconds = n_ns;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_done) begin
            r_pos    <= '0;
            r_phase  <= utcp_pkg::PH_FIXED;
            r_halted <= 1'b0;
            r_err    <= utcp_pkg::ST_OK;
            r_year   <= '0;
            r_month  <= '0;
            r_day    <= '0;
            r_hour   <= '0;
            r_minute <= '0;
            r_second <= '0;
            r_ns     <= '0;
            r_fcnt   <= '0;
        end else if (i_take) begin
            r_pos    <= n_pos;
            r_phase  <= n_phase;
            r_halted <= n_halted;
            r_err    <= n_err;
            r_year   <= n_year;
            r_month  <= n_month;
            r_day    <= n_day;
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_second <= n_second;
            r_ns     <= n_ns;
            r_fcnt   <= n_fcnt;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/utc_timestamp_parser_top.sv =====
// Top level of the utc timestamp parser.
// The slave stream carries one ASCII character per transaction in i_s_tdata,
// with i_s_tlast marking the final character of a timestamp string of the form
// YYYY-MM-DDTHH:MM:SS with an optional dot and fraction.
// For every string the master stream gives exactly one transaction, on the
// final character: status, the six date and time fields and the fraction in
// nanoseconds; on an error the fields are zero.
// Throughput is one character per cycle unless the receiver stalls: the whole
// per-character update is one pass of logic between the parser state
// registers and the output register, loaded as the final character is taken.
// The output register decouples the two sides: while a result waits, a new
// character is taken only in a cycle where that result is taken too.
// When the receiver stalls with a result pending, o_s_tready drops.
// Synchronous reset clears the parser to the start of a string and drops the
// pending result.
`timescale 1ns / 1ps
`default_nettype none

module utc_timestamp_parser_top #(
    parameter int FRACTION_DIGITS = utcp_pkg::FRACTION_DIGITS
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_s_tvalid,
    output logic                                o_s_tready,
    input  wire  [utcp_pkg::IN_TDATA_W-1:0]     i_s_tdata,  // char_code
    input  wire                                 i_s_tlast,  // end_of_text
    output logic                                o_m_tvalid,
    input  wire                                 i_m_tready,
    // status, year, month, day, hour, minute, second, nanoseconds, zero fill
    output logic [utcp_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);

    logic                r_out_valid;
    utcp_pkg::t_result   r_out;
    logic                take;
    logic                done;
    utcp_pkg::t_result   result;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign take       = i_s_tvalid && o_s_tready;

    utcp_core #(
        .FRACTION_DIGITS(FRACTION_DIGITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_char   (i_s_tdata[utcp_pkg::CHAR_W-1:0]),
        .i_last   (i_s_tlast),
        .o_done   (done),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = utcp_pkg::OUT_TDATA_W'(r_out);

endmodule

`default_nettype wire

// ===== tb/sv/utc_timestamp_parser_top_tb.sv =====
// self-checking testbench for the utc timestamp parser top level
`timescale 1ns / 1ps

module utc_timestamp_parser_top_tb;
    import utcp_pkg::*;

    typedef logic [CHAR_W-1:0] t_chars [$];

    localparam int    TIMEOUT_CYCLES = 200000;
    localparam int    RANDOM_CHARS   = 40;
    localparam int    RANDOM_STAMPS  = 2;
    localparam string STAMP_FORM     = "0000-00-00T00:00:00";
    localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_ZULU  = 8'h5A;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   s_tvalid   = 1'b0;
    logic [CHAR_W-1:0]      s_tdata    = '0;
    logic                   s_tlast    = 1'b0;
    logic                   m_tready   = 1'b0;
    logic                   o_s_tready;
    logic                   o_m_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    utc_timestamp_parser_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),   // char_code
        .i_s_tlast  (s_tlast),   // end_of_text
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)  // status, year, month, day, hour, minute, second, ns
    );

    // parser state as predicted
    logic [POS_W-1:0]   cur_pos;
    t_phase             cur_phase;
    logic               cur_halted;
    t_status            cur_status;
    logic [YEAR_W-1:0]  acc_year;
    logic [FIELD_W-1:0] acc_month, acc_day, acc_hour, acc_minute, acc_second;
    logic [19:0]        acc_frac;
    logic [2:0]         frac_count;

    t_result expected_stamps [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int n_chars        = 0;
    int n_strings      = 0;
    int n_results      = 0;
    int n_err_results  = 0;
    int gap_odds       = 0;
    int stall_odds     = 0;
    int stall_left     = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic clear_parser();
        cur_pos    = '0;
        cur_phase  = PH_FIXED;
        cur_halted = 1'b0;
        cur_status = ST_OK;
        acc_year   = '0;
        acc_month  = '0;
        acc_day    = '0;
        acc_hour   = '0;
        acc_minute = '0;
        acc_second = '0;
        acc_frac   = '0;
        frac_count = '0;
    endtask

    task automatic fail_at(input logic [POS_W-1:0] p);
        cur_status = (p <= POS_T) ? ST_DATE_ERR : ST_TIME_ERR;
        cur_phase  = PH_ERROR;
    endtask

    task automatic parse_stamp_char(input logic [CHAR_W-1:0] c, input logic last);
        logic [POS_W-1:0]  p;
        logic [CHAR_W-1:0] sep;
        logic              at_sep;
        logic              digit;
        logic [3:0]        d;
        logic [63:0]       ns;
        t_result           r;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        d = c[3:0];
        if (cur_phase == PH_FIXED) begin
            p = cur_pos;
            at_sep = 1'b1;
            sep = CH_NUL;
            case (p)
                POS_DASH_1, POS_DASH_2:   sep = CH_DASH;
                POS_T:                    sep = CH_T;
                POS_COLON_1, POS_COLON_2: sep = CH_COLON;
                default:                  at_sep = 1'b0;
            endcase
            if (at_sep) begin
                if (c != sep)
                    fail_at(p);
                cur_halted = 1'b0;
            end else if (p < POS_FIXED_LEN) begin
                if (c == CH_NUL) begin
                    fail_at(p);
                end else if (!cur_halted && digit) begin
                    if (p <= POS_YEAR_END)
                        acc_year = YEAR_W'(acc_year * 10 + d);
                    else if (p <= POS_MONTH_END)
                        acc_month = FIELD_W'(acc_month * 10 + d);
                    else if (p <= POS_DAY_END)
                        acc_day = FIELD_W'(acc_day * 10 + d);
                    else if (p <= POS_HOUR_END)
                        acc_hour = FIELD_W'(acc_hour * 10 + d);
                    else if (p <= POS_MINUTE_END)
                        acc_minute = FIELD_W'(acc_minute * 10 + d);
                    else
                        acc_second = FIELD_W'(acc_second * 10 + d);
                end else begin
                    cur_halted = 1'b1;
                end
            end else begin
                cur_phase = (c == CH_DOT) ? PH_FRAC : PH_DONE;
            end
            if (cur_phase != PH_ERROR) begin
                cur_pos = p + 1'b1;
                if (last && cur_pos < POS_FIXED_LEN)
                    fail_at(cur_pos);
            end
        end else if (cur_phase == PH_FRAC) begin
            if (digit) begin
                if (frac_count < FRACTION_DIGITS) begin
                    acc_frac   = 20'(acc_frac * 10 + d);
                    frac_count = frac_count + 1'b1;
                end
            end else begin
                cur_phase = PH_DONE;
            end
        end
        if (last) begin
            r = '0;
            r.status = cur_status;
            if (cur_status == ST_OK) begin
                ns = 64'(acc_frac);
                for (int i = frac_count; i < 9; i++)
                    ns = ns * 10;
                r.year        = acc_year;
                r.month       = acc_month;
                r.day         = acc_day;
                r.hour        = acc_hour;
                r.minute      = acc_minute;
                r.second      = acc_second;
                r.nanoseconds = ns[NS_W-1:0];
            end
            expected_stamps.push_back(r);
            clear_parser();
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] result %0d: %s", $realtime, n_results, msg);
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // checks each result transaction and predicts from each character transaction
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n) begin
            if (o_m_tvalid && m_tready) begin
                got = t_result'(o_m_tdata[RESULT_W-1:0]);
                if (expected_stamps.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    want = expected_stamps.pop_front();
                    compare_field("status", got.status, want.status);
                    compare_field("year", got.year, want.year);
                    compare_field("month", got.month, want.month);
                    compare_field("day", got.day, want.day);
                    compare_field("hour", got.hour, want.hour);
                    compare_field("minute", got.minute, want.minute);
                    compare_field("second", got.second, want.second);
                    compare_field("nanoseconds", got.nanoseconds, want.nanoseconds);
                    compare_field("zero fill", o_m_tdata[OUT_TDATA_W-1:RESULT_W], 0);
                    if (want.status != ST_OK)
                        n_err_results++;
                end
                n_results++;
            end
            if (s_tvalid && o_s_tready)
                parse_stamp_char(s_tdata, s_tlast);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     expected_stamps.size());
            $display("utc_timestamp_parser_top: mismatch");
            $finish;
        end
    end

    // receiver stalls in bursts
    always @(negedge i_clk) begin
        if (stall_odds == 0) begin
            stall_left <= 0;
            m_tready   <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if ($urandom_range(1, stall_odds) == 1) begin
            stall_left <= int'($urandom_range(0, 13));
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            s_tvalid <= 1'b0;
            s_tdata  <= CHAR_W'($urandom_range(0, 255));
            s_tlast  <= 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        n_chars++;
        @(negedge i_clk);
    endtask

    task automatic send_chars(input t_chars q);
        foreach (q[i])
            send_char(q[i], i == q.size() - 1);
        n_strings++;
    endtask

    function automatic t_chars text_chars(input string s);
        t_chars q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    function automatic logic [CHAR_W-1:0] odd_char();
        case ($urandom_range(0, 4))
            0:       return CH_BLANK;
            1:       return CH_PLUS;
            2:       return CH_DASH;
            3:       return CH_NUL;
            default: return CHAR_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random_stamp();
        t_chars            q;
        int                kind, pick, n;
        logic [CHAR_W-1:0] c;
        kind = $urandom_range(0, 99);
        pick = $urandom_range(0, 7);
        for (int i = 0; i < STAMP_FORM.len(); i++) begin
            if (STAMP_FORM[i] != CH_ZERO) q.push_back(STAMP_FORM[i]);
            else if (pick == 0)           q.push_back(CH_ZERO);
            else if (pick == 1)           q.push_back(CH_NINE);
            else q.push_back(CHAR_W'(CH_ZERO + $urandom_range(0, 9)));
        end
        if (kind < 15) begin
            q[$urandom_range(0, 18)] = odd_char();
        end else if (kind < 27) begin
            n = 3 * $urandom_range(1, 5) + 1;
            do c = CHAR_W'($urandom_range(0, 255)); while (c == q[n]);
            q[n] = c;
        end else if (kind < 37) begin
            n = $urandom_range(1, 18);
            while (q.size() > n)
                q.pop_back();
        end else if (kind < 45) begin
            q.delete();
            repeat ($urandom_range(1, 30))
                q.push_back(CHAR_W'($urandom_range(0, 255)));
        end
        if (kind < 27 || kind >= 45) begin
            pick = $urandom_range(0, 5);
            if (pick >= 2) begin
                q.push_back(CH_DOT);
                repeat ($urandom_range(0, 9))
                    q.push_back(CHAR_W'(CH_ZERO + $urandom_range(0, 9)));
                if (pick == 5) begin
                    q.push_back(odd_char());
                    q.push_back(CHAR_W'(CH_ZERO + $urandom_range(0, 9)));
                end
            end else if (pick == 1) begin
                q.push_back(odd_char());
            end
            if ($urandom_range(0, 1) == 1)
                q.push_back(CH_ZULU);
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 4))
                    q.push_back(CHAR_W'($urandom_range(0, 255)));
        end
        send_chars(q);
    endtask

    task automatic test_valid_stamps();
        send_chars(text_chars("2024-02-29T23:59:59.123456Z"));
        send_chars(text_chars("0000-00-00T00:00:00"));
        send_chars(text_chars("9999-99-99T99:99:99.999999"));
    endtask

    task automatic test_fraction_forms();
        send_chars(text_chars("1999-12-31T00:00:00.1234567891Z"));
        send_chars(text_chars("2024-01-01T12:00:00."));
        send_chars(text_chars("2024-01-01T12:00:00Z trailing"));
        send_chars(text_chars("2024-01-01T12:00:00.5"));
        send_chars(text_chars("2024-01-01T12:00:00.12x34"));
    endtask

    task automatic test_short_strings();
        send_chars(text_chars("2"));
        send_chars(text_chars("2024-"));
        send_chars(text_chars("2024-01-01"));
        send_chars(text_chars("2024-01-01T"));
        send_chars(text_chars("2024-01-01T12:00:0"));
    endtask

    task automatic test_separator_errors();
        send_chars(text_chars("2024/01-01T00:00:00"));
        send_chars(text_chars("2024-01-01 00:00:00"));
        send_chars(text_chars("2024-01-01T00-00:00"));
        send_chars(text_chars("2024-01-01T00:00.00"));
        send_chars(text_chars("2024-01-01X"));
        send_chars(text_chars("2024=01-01T00:00:00.123 ignored after error"));
    endtask

    task automatic test_odd_chars();
        t_chars q;
        q = text_chars("2024-01-01T00:00:00");
        q[2] = CH_NUL;
        send_chars(q);
        q = text_chars("2024-01-01T00:00:00");
        q[14] = CH_NUL;
        send_chars(q);
        q = text_chars("2024-01-01T00:00:00.12345");
        q[21] = CH_NUL;
        send_chars(q);
        q = text_chars("2024-01-01T00:00:00.5");
        q[19] = CH_NUL;
        send_chars(q);
        q = text_chars("2024-01-01T00:00:00");
        q[1] = 8'hFF;
        q[8] = 8'h80;
        q[17] = CH_SLASH;
        send_chars(q);
        send_chars(text_chars("20 4-+1-0aT1 :-5:5x.000001"));
    endtask

    task automatic test_random_stamps();
        int c0, s0;
        c0 = n_chars;
        s0 = n_strings;
        while (n_chars - c0 < RANDOM_CHARS || n_strings - s0 < RANDOM_STAMPS) begin
            gap_odds   = ($urandom_range(0, 2) == 0) ? 0 : 3;
            stall_odds = ($urandom_range(0, 2) == 0) ? 0 : 5;
            send_random_stamp();
        end
    endtask

    task automatic test_random_no_idle();
        gap_odds   = 0;
        stall_odds = 0;
        repeat (2)
            send_random_stamp();
    endtask

    initial begin
        clear_parser();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        gap_odds   = 4;
        stall_odds = 5;
        test_valid_stamps();
        test_fraction_forms();
        test_short_strings();
        test_separator_errors();
        test_odd_chars();
        test_random_stamps();
        test_random_no_idle();
        s_tvalid <= 1'b0;
        while (expected_stamps.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        $display("sent %0d strings in %0d characters, checked %0d results (%0d errors)",
                 n_strings, n_chars, n_results, n_err_results);
        $display("covered valid, short, broken, noisy and fraction stamps with stalls");
        if (mismatch_count == 0 && expected_stamps.size() == 0) begin
            $display("utc_timestamp_parser_top: match");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("utc_timestamp_parser_top: mismatch");
        end
        $finish;
    end

endmodule
